### rtl/core/vrfc_pkg.sv
// ---------------------------------------------------------------------------
// vrfc_pkg: shared types and constants for the reflector floor controller
// Frame codes, status and action codes, and the queue entry type.
// ---------------------------------------------------------------------------
package vrfc_pkg;

  localparam logic [7:0] FT_POLL   = 8'hF0;
  localparam logic [7:0] FT_UNLINK = 8'hF1;
  localparam logic [7:0] FT_CTYPE  = 8'h64;
  localparam logic [7:0] FT_TARGET = 8'h65;
  localparam logic [7:0] FT_SOURCE = 8'h66;
  localparam logic [7:0] FT_EOT    = 8'h80;

  localparam logic [15:0] PEER_TIMEOUT_RST = 16'd60000;
  localparam logic [15:0] WDOG_TIMEOUT_RST = 16'd1500;
  localparam int unsigned MaxResults = 16;

  typedef enum logic [1:0] {
    ACT_STATUS  = 2'd0,
    ACT_ECHO    = 2'd1,
    ACT_FORWARD = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTTALK  = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_RELEASED = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_PEER_TIMEOUT = 1'b0,
    REG_WDOG_TIMEOUT = 1'b1
  } reg_e;

  // classified item handed from front to back
  typedef struct packed {
    logic        tick;
    logic [47:0] addr;
    logic [7:0]  ft;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [15:0] el;
  } item_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DECIDE,
    BK_FWD,
    BK_EMIT
  } back_state_e;

endpackage

### rtl/core/vrfc_queue.sv
// ---------------------------------------------------------------------------
// vrfc_queue: two-entry item queue
// Decouples input acceptance from the peer table sequencer.
// ---------------------------------------------------------------------------
module vrfc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vrfc_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vrfc_pkg::item_t out_item_o
);
  import vrfc_pkg::*;

  item_t      mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rptr_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### rtl/core/vrfc_back.sv
// ---------------------------------------------------------------------------
// vrfc_back: peer table sequencer
// Walks the peer slots one per cycle for matching, aging and forwarding; a stalled output holds the forward walk.
// ---------------------------------------------------------------------------
module vrfc_back #(
  parameter int MAX_PEERS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vrfc_pkg::item_t in_item_i,
  input  logic [15:0]     peer_timeout_i,
  input  logic [15:0]     wdog_timeout_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [111:0]    out_data_o,
  output logic            out_last_o
);
  import vrfc_pkg::*;

  localparam int SW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int CW = $clog2(MAX_PEERS + 1);
  localparam int RW = $clog2(MaxResults + 1);

  back_state_e state_q, state_d;
  item_t       it_q;
  logic [CW-1:0] idx_q, idx_d;
  logic [SW-1:0] sidx;
  logic [MAX_PEERS-1:0] valid_q;
  logic [47:0] addr_q [MAX_PEERS];
  logic [15:0] idle_q [MAX_PEERS];

  logic        talker_q;
  logic [SW-1:0] tslot_q;
  logic [2:0]  hflags_q;
  logic [7:0]  ctype_q;
  logic [23:0] target_q, source_q;
  logic        wd_run_q;
  logic [15:0] wd_ms_q;

  logic          found_q, free_q, exp_q;
  logic [SW-1:0] fslot_q, free_slot_q, exp_slot_q;
  logic          hdr_q;
  logic [RW-1:0] nres_q;
  // pending status results: removed, then released, then final
  logic          p_rem_q, p_rel_q, p_fin_q;
  logic [2:0]    fin_st_q;
  logic [47:0]   rem_addr_q;
  logic [SW-1:0] rem_slot_q;

  logic          ov_q;
  logic [1:0]    o_act_q;
  logic [47:0]   o_addr_q;
  logic [3:0]    o_slot_q;
  logic [2:0]    o_st_q;
  logic          o_last_q;

  logic [16:0] idle_sum;
  logic [15:0] idle_sat;
  logic [16:0] wd_sum;
  logic [15:0] wd_sat;
  logic        out_free;

  assign sidx     = idx_q[SW-1:0];
  assign out_free = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == BK_IDLE);
  assign out_valid_o = ov_q;
  assign out_last_o  = o_last_q;
  assign out_data_o  = {5'd0, (ctype_q == 8'd0), target_q, source_q,
                        hdr_q, o_st_q, o_slot_q, o_addr_q, o_act_q};
  assign idle_sum = {1'b0, idle_q[sidx]} + {1'b0, it_q.el};
  assign idle_sat = idle_sum[16] ? 16'hFFFF : idle_sum[15:0];
  assign wd_sum   = {1'b0, wd_ms_q} + {1'b0, it_q.el};
  assign wd_sat   = wd_sum[16] ? 16'hFFFF : wd_sum[15:0];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      BK_IDLE:   if (in_valid_i) begin state_d = BK_SCAN; idx_d = '0; end
      BK_SCAN:   if (idx_q == CW'(MAX_PEERS - 1)) state_d = BK_DECIDE;
                 else idx_d = idx_q + 1'b1;
      BK_DECIDE: begin state_d = BK_FWD; idx_d = '0; end
      BK_FWD:    if (out_free && (idx_q == CW'(MAX_PEERS - 1) || !p_fin_q))
                   state_d = BK_EMIT;
                 else if (out_free) idx_d = idx_q + 1'b1;
      BK_EMIT:   if (out_free && !p_rem_q && !p_rel_q && !p_fin_q) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      idx_q    <= '0;
      valid_q  <= '0;
      talker_q <= 1'b0;
      tslot_q  <= '0;
      hflags_q <= '0;
      ctype_q  <= '0;
      target_q <= '0;
      source_q <= '0;
      wd_run_q <= 1'b0;
      wd_ms_q  <= '0;
      ov_q     <= 1'b0;
      p_rem_q  <= 1'b0;
      p_rel_q  <= 1'b0;
      p_fin_q  <= 1'b0;
      hdr_q    <= 1'b0;
      nres_q   <= '0;
      found_q  <= 1'b0;
      free_q   <= 1'b0;
      exp_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      case (state_q)
        BK_IDLE: if (in_valid_i) begin
          it_q    <= in_item_i;
          found_q <= 1'b0;
          free_q  <= 1'b0;
          exp_q   <= 1'b0;
          hdr_q   <= 1'b0;
          nres_q  <= '0;
          p_rem_q <= 1'b0;
          p_rel_q <= 1'b0;
          p_fin_q <= 1'b0;
        end
        BK_SCAN: if (valid_q[sidx]) begin
          if (it_q.tick) begin
            idle_q[sidx] <= idle_sat;
            if (!exp_q && peer_timeout_i != 16'd0 && idle_sat >= peer_timeout_i) begin
              exp_q <= 1'b1;
              exp_slot_q <= sidx;
            end
          end else if (!found_q && addr_q[sidx] == it_q.addr) begin
            found_q <= 1'b1;
            fslot_q <= sidx;
          end
        end else if (!free_q) begin
          free_q <= 1'b1;
          free_slot_q <= sidx;
        end
        BK_DECIDE: begin
          fin_st_q <= ST_OK;
          if (it_q.tick) begin
            if (exp_q) begin
              valid_q[exp_slot_q] <= 1'b0;
              p_rem_q <= 1'b1;
              rem_addr_q <= addr_q[exp_slot_q];
              rem_slot_q <= exp_slot_q;
              if (talker_q && tslot_q == exp_slot_q) begin
                talker_q <= 1'b0;
                wd_run_q <= 1'b0;
                p_rel_q  <= 1'b1;
              end
            end
            if (wd_run_q && !(exp_q && talker_q && tslot_q == exp_slot_q)) begin
              wd_ms_q <= wd_sat;
              if (wdog_timeout_i != 16'd0 && wd_sat >= wdog_timeout_i) begin
                talker_q <= 1'b0;
                wd_run_q <= 1'b0;
                p_rel_q  <= 1'b1;
              end
            end
            p_fin_q <= !exp_q && !(wd_run_q && wdog_timeout_i != 16'd0
                       && wd_sat >= wdog_timeout_i);
          end else if (it_q.ft == FT_POLL) begin
            if (found_q || free_q) begin
              if (!found_q) begin
                valid_q[free_slot_q] <= 1'b1;
                addr_q[free_slot_q]  <= it_q.addr;
                idle_q[free_slot_q]  <= '0;
              end else idle_q[fslot_q] <= '0;
              ov_q     <= 1'b1;
              o_act_q  <= ACT_ECHO;
              o_addr_q <= it_q.addr;
              o_slot_q <= 4'(found_q ? fslot_q : free_slot_q);
              o_st_q   <= ST_OK;
              o_last_q <= 1'b1;
            end else begin
              fin_st_q <= ST_FULL;
              p_fin_q  <= 1'b1;
            end
          end else if (!found_q) begin
            fin_st_q <= ST_UNKNOWN;
            p_fin_q  <= 1'b1;
          end else if (it_q.ft == FT_UNLINK) begin
            valid_q[fslot_q] <= 1'b0;
            p_rem_q    <= 1'b1;
            rem_addr_q <= addr_q[fslot_q];
            rem_slot_q <= fslot_q;
            if (talker_q && tslot_q == fslot_q) begin
              talker_q <= 1'b0;
              wd_run_q <= 1'b0;
              p_rel_q  <= 1'b1;
            end
          end else begin
            idle_q[fslot_q] <= '0;
            if (talker_q && tslot_q != fslot_q) begin
              fin_st_q <= ST_NOTTALK;
              p_fin_q  <= 1'b1;
            end else begin
              talker_q <= 1'b1;
              tslot_q  <= fslot_q;
              wd_run_q <= 1'b1;
              wd_ms_q  <= '0;
              if (!talker_q) hflags_q <= '0;
              if (it_q.ft == FT_CTYPE && (!hflags_q[0] || !talker_q)) begin
                ctype_q <= it_q.b1;
                hflags_q <= (talker_q ? hflags_q : 3'b0) | 3'b001;
              end
              if (it_q.ft == FT_TARGET && (!hflags_q[1] || !talker_q)) begin
                target_q <= {it_q.b1, it_q.b2, it_q.b3};
                hflags_q <= (talker_q ? hflags_q : 3'b0) | 3'b010;
              end
              if (it_q.ft == FT_SOURCE && talker_q && hflags_q == 3'b011) begin
                source_q <= {it_q.b1, it_q.b2, it_q.b3};
                hflags_q <= 3'b111;
                hdr_q    <= 1'b1;
              end
              if (it_q.ft == FT_EOT) begin
                talker_q <= 1'b0;
                wd_run_q <= 1'b0;
                fin_st_q <= ST_RELEASED;
              end
              p_fin_q <= 1'b1;
              // mark forward walk with fslot in found_q, talker path only
              found_q <= 1'b1;
              exp_q   <= 1'b1;
            end
          end
        end
        BK_FWD: if (out_free) begin
          // exp_q flags a talker frame on packet items
          if (!it_q.tick && exp_q && p_fin_q && valid_q[sidx] && sidx != fslot_q
              && nres_q < RW'(MaxResults - 1)) begin
            ov_q     <= 1'b1;
            o_act_q  <= ACT_FORWARD;
            o_addr_q <= addr_q[sidx];
            o_slot_q <= 4'(sidx);
            o_st_q   <= ST_OK;
            o_last_q <= 1'b0;
            nres_q   <= nres_q + 1'b1;
          end
        end
        BK_EMIT: if (out_free) begin
          if (p_rem_q) begin
            ov_q <= 1'b1; o_act_q <= ACT_STATUS; o_addr_q <= rem_addr_q;
            o_slot_q <= 4'(rem_slot_q); o_st_q <= ST_REMOVED;
            o_last_q <= !p_rel_q && !p_fin_q;
            p_rem_q <= 1'b0;
          end else if (p_rel_q) begin
            ov_q <= 1'b1; o_act_q <= ACT_STATUS; o_addr_q <= '0;
            o_slot_q <= '0; o_st_q <= ST_RELEASED; o_last_q <= !p_fin_q;
            p_rel_q <= 1'b0;
          end else if (p_fin_q) begin
            ov_q <= 1'b1; o_act_q <= ACT_STATUS; o_addr_q <= '0;
            o_slot_q <= '0; o_st_q <= fin_st_q; o_last_q <= 1'b1;
            p_fin_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/core/voice_reflector_floor_control.sv
// ---------------------------------------------------------------------------
// voice_reflector_floor_control: talk floor arbiter for a voice reflector
//
//  channel  dir  handshake          payload
//  s_axis   in   tvalid/tready      cmd, addr, frame bytes, elapsed
//  m_axis   out  tvalid/tready      action, dest, status, latched header, tlast
//  apb      in   psel/penable       peer and watchdog timeouts
//
// The sequencer scans every peer slot for each item, then decides. An item
// without a final status (an echo, or a removal) leaves the forward walk at once
// and then emits its status results (removed, released). An item that ends in a
// final status walks every slot again; forwarded copies leave during that walk.
// A stalled output holds the sequencer. A two-entry queue keeps accepting items,
// until it holds two, while the sequencer works.
// Reset clears the table valid bits and floor state at once.
// ---------------------------------------------------------------------------
module voice_reflector_floor_control #(
  parameter int MAX_PEERS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic         s_axis_tuser,   // cmd
  input  logic [95:0]  s_axis_tdata,   // peer_addr, frame_type, byte_one..three, elapsed_ms
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,   // action, dest_addr, dest_slot, status,
                                       // header_ready, source_id, target_id, group_call
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import vrfc_pkg::*;

  item_t in_item, q_item;
  logic  q_valid, q_ready;
  logic [15:0] ptmo_q, wtmo_q;
  logic  wr_en;
  logic [111:0] bk_data;

  assign in_item = '{tick: s_axis_tuser, addr: s_axis_tdata[47:0],
                     ft: s_axis_tdata[55:48], b1: s_axis_tdata[63:56],
                     b2: s_axis_tdata[71:64], b3: s_axis_tdata[79:72],
                     el: s_axis_tdata[95:80]};

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  always_comb begin
    prdata = '0;
    case (reg_e'(paddr[2]))
      REG_PEER_TIMEOUT: prdata = {16'd0, ptmo_q};
      REG_WDOG_TIMEOUT: prdata = {16'd0, wtmo_q};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptmo_q <= PEER_TIMEOUT_RST;
      wtmo_q <= WDOG_TIMEOUT_RST;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      if (reg_e'(paddr[2]) == REG_PEER_TIMEOUT) ptmo_q <= pwdata[15:0];
      else wtmo_q <= pwdata[15:0];
    end
  end

  vrfc_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_item_i(in_item),
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_item_o(q_item)
  );

  vrfc_back #(.MAX_PEERS(MAX_PEERS)) u_back (
    .clk_i, .rst_ni,
    .in_valid_i(q_valid), .in_ready_o(q_ready), .in_item_i(q_item),
    .peer_timeout_i(ptmo_q), .wdog_timeout_i(wtmo_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_data_o(bk_data), .out_last_o(m_axis_tlast)
  );

  assign m_axis_tdata = bk_data;

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output changed while stalled");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output dropped while stalled");
endmodule

### bench/voice_reflector_floor_control_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// voice_reflector_floor_control_test: self-checking bench for the floor arbiter
// Drives packet and tick transactions into the stream input, writes the two
// timeouts over apb while idle, predicts every result transaction and
// compares it with the output stream in order.
// ---------------------------------------------------------------------------
module voice_reflector_floor_control_test;
  import vrfc_pkg::*;

  localparam int NPEER = 16;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic         s_axis_tuser = 1'b0;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  voice_reflector_floor_control #(.MAX_PEERS(NPEER)) dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("[voice_reflector_floor_control] ERROR");
    $finish;
  end

  // predictor state
  logic [15:0] peer_tmo, wdog_tmo;
  logic        linked [NPEER];
  logic [47:0] link_addr [NPEER];
  logic [15:0] link_idle [NPEER];
  logic        floor_held;
  logic [3:0]  floor_slot;
  logic [2:0]  hdr_seen;
  logic [7:0]  latched_ctype;
  logic [23:0] latched_target, latched_source;
  logic        wdog_on;
  logic [15:0] wdog_count;

  typedef struct {
    logic [111:0] word;
    logic         lst;
  } result_t;

  result_t     pending_results[$];
  result_t     item_results[$];
  int          errors = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  logic [47:0] addr_pool[20];

  function automatic logic [15:0] sat16(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void add_result(action_e act, logic [47:0] a, logic [3:0] slot,
                                     status_e st);
    result_t r;
    if (item_results.size() >= MaxResults) return;
    r.word = '0;
    r.word[1:0]   = act;
    r.word[49:2]  = a;
    r.word[53:50] = slot;
    r.word[56:54] = st;
    r.lst = 1'b0;
    item_results = {item_results, r};
  endfunction

  function automatic void drop_peer(int s);
    linked[s] = 1'b0;
    add_result(ACT_STATUS, link_addr[s], s[3:0], ST_REMOVED);
    if (floor_held && floor_slot == s[3:0]) begin
      floor_held = 1'b0;
      wdog_on = 1'b0;
      add_result(ACT_STATUS, '0, '0, ST_RELEASED);
    end
  endfunction

  function automatic void predict_floor(logic tick, logic [95:0] d);
    logic [47:0] a;
    logic [7:0]  ft;
    logic [23:0] id;
    logic [15:0] el;
    logic        hdr;
    int          s, ex;
    a = d[47:0];
    ft = d[55:48];
    id = {d[63:56], d[71:64], d[79:72]};
    el = d[95:80];
    hdr = 1'b0;
    s = -1;
    ex = -1;
    item_results.delete();
    if (!tick) begin
      for (int i = 0; i < NPEER; i++)
        if (s < 0 && linked[i] && link_addr[i] == a) s = i;
      if (ft == FT_POLL) begin
        if (s < 0) begin
          for (int i = 0; i < NPEER; i++)
            if (s < 0 && !linked[i]) s = i;
          if (s >= 0) begin
            linked[s] = 1'b1;
            link_addr[s] = a;
          end
        end
        if (s < 0) add_result(ACT_STATUS, '0, '0, ST_FULL);
        else begin
          link_idle[s] = '0;
          add_result(ACT_ECHO, a, s[3:0], ST_OK);
        end
      end else if (s < 0) begin
        add_result(ACT_STATUS, '0, '0, ST_UNKNOWN);
      end else if (ft == FT_UNLINK) begin
        drop_peer(s);
      end else begin
        link_idle[s] = '0;
        if (!floor_held) begin
          floor_held = 1'b1;
          floor_slot = s[3:0];
          hdr_seen = '0;
        end
        if (floor_slot != s[3:0]) begin
          add_result(ACT_STATUS, '0, '0, ST_NOTTALK);
        end else begin
          wdog_on = 1'b1;
          wdog_count = '0;
          if (ft == FT_CTYPE && !hdr_seen[0]) begin
            latched_ctype = id[23:16];
            hdr_seen[0] = 1'b1;
          end
          if (ft == FT_TARGET && !hdr_seen[1]) begin
            latched_target = id;
            hdr_seen[1] = 1'b1;
          end
          if (ft == FT_SOURCE && hdr_seen[1:0] == 2'b11 && !hdr_seen[2]) begin
            latched_source = id;
            hdr_seen[2] = 1'b1;
            hdr = 1'b1;
          end
          for (int i = 0; i < NPEER; i++)
            if (linked[i] && i != s && item_results.size() < MaxResults - 1)
              add_result(ACT_FORWARD, link_addr[i], i[3:0], ST_OK);
          if (ft == FT_EOT) begin
            floor_held = 1'b0;
            wdog_on = 1'b0;
            add_result(ACT_STATUS, '0, '0, ST_RELEASED);
          end else begin
            add_result(ACT_STATUS, '0, '0, ST_OK);
          end
        end
      end
    end else begin
      for (int i = 0; i < NPEER; i++) begin
        if (linked[i]) begin
          link_idle[i] = sat16(link_idle[i], el);
          if (ex < 0 && peer_tmo != 0 && link_idle[i] >= peer_tmo) ex = i;
        end
      end
      if (ex >= 0) drop_peer(ex);
      if (wdog_on) begin
        wdog_count = sat16(wdog_count, el);
        if (wdog_tmo != 0 && wdog_count >= wdog_tmo) begin
          floor_held = 1'b0;
          wdog_on = 1'b0;
          add_result(ACT_STATUS, '0, '0, ST_RELEASED);
        end
      end
      if (item_results.size() == 0) add_result(ACT_STATUS, '0, '0, ST_OK);
    end
    foreach (item_results[k]) begin
      item_results[k].word[57]     = hdr;
      item_results[k].word[81:58]  = latched_source;
      item_results[k].word[105:82] = latched_target;
      item_results[k].word[106]    = (latched_ctype == 8'd0);
      item_results[k].lst = (k == item_results.size() - 1);
      pending_results = {pending_results, item_results[k]};
    end
  endfunction

  // sink side: random stall per cycle
  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction data=%h last=%b", $time,
                 m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (m_axis_tdata !== e.word || m_axis_tlast !== e.lst) begin
          $display("%0t: mismatch expected act=%0d addr=%h slot=%0d st=%0d hdr=%b",
                   $time, e.word[1:0], e.word[49:2], e.word[53:50], e.word[56:54],
                   e.word[57]);
          $display("   src=%h tgt=%h grp=%b last=%b", e.word[81:58], e.word[105:82],
                   e.word[106], e.lst);
          $display("   actual act=%0d addr=%h slot=%0d st=%0d hdr=%b src=%h tgt=%h",
                   m_axis_tdata[1:0], m_axis_tdata[49:2], m_axis_tdata[53:50],
                   m_axis_tdata[56:54], m_axis_tdata[57], m_axis_tdata[81:58],
                   m_axis_tdata[105:82]);
          $display("   grp=%b last=%b pad=%h", m_axis_tdata[106], m_axis_tlast,
                   m_axis_tdata[111:107]);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic tick, logic [47:0] a, logic [7:0] ft, logic [23:0] id,
                           logic [15:0] el);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= tick;
    s_axis_tdata  <= {el, id[7:0], id[15:8], id[23:16], ft, a};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_floor(tick, {el, id[7:0], id[15:8], id[23:16], ft, a});
  endtask

  task automatic packet(logic [47:0] a, logic [7:0] ft, logic [23:0] id = '0);
    send_item(1'b0, a, ft, id, 16'($urandom));
  endtask

  task automatic tick(logic [15:0] el);
    send_item(1'b1, 48'($urandom) << 16 | 48'($urandom), 8'($urandom), 24'($urandom), el);
  endtask

  task automatic drain;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e idx, logic [15:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_PEER_TIMEOUT) peer_tmo = val;
    else wdog_tmo = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic test_link_and_echo;
    packet(48'h0, FT_POLL);
    packet(48'hFFFF_FFFF_FFFF, FT_POLL);
    packet(48'h0, FT_POLL);                     // refresh existing
    packet(48'h1234_5678_9ABC, FT_CTYPE);       // unknown source
    packet(48'h1234_5678_9ABC, FT_UNLINK);      // unlink from unknown
    packet(48'hFFFF_FFFF_FFFF, FT_UNLINK);
    packet(48'hFFFF_FFFF_FFFF, FT_POLL);
  endtask

  task automatic test_floor_and_header;
    packet(48'h0, FT_CTYPE, 24'h00_0000);       // takes floor, group call
    packet(48'hFFFF_FFFF_FFFF, FT_TARGET);      // not talker
    packet(48'h0, FT_TARGET, 24'hFF_FFFF);
    packet(48'h0, FT_SOURCE, 24'hA5_5A_C3);     // header done
    packet(48'h0, FT_SOURCE, 24'h11_2233);      // already done
    packet(48'h0, 8'hFF, 24'hFF_FFFF);
    packet(48'h0, FT_EOT);
    packet(48'hFFFF_FFFF_FFFF, FT_CTYPE, 24'hFF_0000);
    packet(48'hFFFF_FFFF_FFFF, FT_UNLINK);      // talker unlinked
    packet(48'h0, 8'h00);
  endtask

  task automatic test_ticks_and_expiry;
    tick(16'd0);
    tick(16'd1499);
    tick(16'd1);                                // watchdog release
    tick(16'hFFFF);                             // peer expiry
    tick(16'hFFFF);
  endtask

  task automatic test_full_table;
    for (int i = 0; i < 18; i++) packet(addr_pool[i], FT_POLL);
    packet(addr_pool[3], FT_TARGET, 24'h0F_0F0F); // forward to every other peer
    packet(addr_pool[3], FT_EOT);
  endtask

  task automatic test_random(int count);
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 25) packet(addr_pool[$urandom_range(19)], FT_POLL);
      else if (k < 65) begin
        case ($urandom_range(5))
          0: packet(addr_pool[$urandom_range(19)], FT_CTYPE, 24'($urandom) & 24'h01FFFF);
          1: packet(addr_pool[$urandom_range(19)], FT_TARGET, 24'($urandom));
          2: packet(addr_pool[$urandom_range(19)], FT_SOURCE, 24'($urandom));
          3: packet(addr_pool[$urandom_range(19)], FT_EOT, 24'($urandom));
          default: packet(addr_pool[$urandom_range(19)], 8'($urandom), 24'($urandom));
        endcase
      end else if (k < 73) packet(addr_pool[$urandom_range(19)], FT_UNLINK);
      else if (k < 90) begin
        if ($urandom_range(9) == 0) tick(16'($urandom));
        else tick(16'($urandom_range(800)));
      end else packet({$urandom, 16'($urandom)}, 8'($urandom), 24'($urandom));
    end
  endtask

  initial begin
    peer_tmo = PEER_TIMEOUT_RST;
    wdog_tmo = WDOG_TIMEOUT_RST;
    for (int i = 0; i < NPEER; i++) begin
      linked[i] = 1'b0;
      link_addr[i] = '0;
      link_idle[i] = '0;
    end
    floor_held = 1'b0;
    floor_slot = '0;
    hdr_seen = '0;
    latched_ctype = '0;
    latched_target = '0;
    latched_source = '0;
    wdog_on = 1'b0;
    wdog_count = '0;
    for (int i = 0; i < 20; i++) addr_pool[i] = {$urandom, 16'($urandom)};
    addr_pool[18] = 48'h0;
    addr_pool[19] = 48'hFFFF_FFFF_FFFF;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_link_and_echo;
    test_floor_and_header;
    test_ticks_and_expiry;
    test_full_table;
    drain;
    apb_write(REG_PEER_TIMEOUT, 16'd1);
    apb_write(REG_WDOG_TIMEOUT, 16'd1);
    test_ticks_and_expiry;
    drain;
    apb_write(REG_PEER_TIMEOUT, 16'd65535);
    apb_write(REG_WDOG_TIMEOUT, 16'd65535);
    tick(16'hFFFF);
    test_full_table;
    tick(16'hFFFF);
    tick(16'hFFFF);
    drain;
    apb_write(REG_PEER_TIMEOUT, 16'd2500);
    apb_write(REG_WDOG_TIMEOUT, 16'd900);
    test_random(40);
    drain;
    src_idle_pct = 45;
    apb_write(REG_PEER_TIMEOUT, 16'd1200);
    apb_write(REG_WDOG_TIMEOUT, 16'd300);
    test_random(40);
    drain;
    src_idle_pct = 0;
    snk_stall_pct = 45;
    apb_write(REG_PEER_TIMEOUT, PEER_TIMEOUT_RST);
    apb_write(REG_WDOG_TIMEOUT, WDOG_TIMEOUT_RST);
    test_random(40);
    drain;
    src_idle_pct = 32;
    snk_stall_pct = 32;
    apb_write(REG_PEER_TIMEOUT, 16'd4000);
    apb_write(REG_WDOG_TIMEOUT, 16'd2000);
    test_random(40);
    drain;

    if (errors == 0) begin
      $display("[voice_reflector_floor_control] OK");
    end else begin
      $display("[voice_reflector_floor_control] ERROR");
    end
    $finish;
  end

endmodule
